/* hdl/fptc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fptc_pkg;

   typedef struct packed {
      logic valid;
      logic neg;
   } ctrl_type;

   typedef enum logic [2:0] {
      REG_SENSITIVE_START   = 3'd0,
      REG_DETECTOR_PITCH    = 3'd1,
      REG_DIE_PITCH         = 3'd2,
      REG_CHANNEL_PITCH     = 3'd3,
      REG_DETECTORS_IN_MAT  = 3'd4,
      REG_DIES_PER_DETECTOR = 3'd5,
      REG_CHANNELS_PER_DIE  = 3'd6
   } reg_index_type;

   localparam int REG_INDEX_W = 3;

   localparam int START_RESET      = -266404;
   localparam logic [23:0] DETECTOR_PITCH_RESET = 24'd133612;
   localparam logic [23:0] DIE_PITCH_RESET      = 24'd66437;
   localparam logic [15:0] CHANNEL_PITCH_RESET  = 16'd1024;
   localparam logic [4:0]  DETECTORS_RESET      = 5'd4;
   localparam logic [2:0]  DIES_RESET           = 3'd2;
   localparam logic [7:0]  CHANNELS_RESET       = 8'd64;

   localparam int PITCH_W         = 24;
   localparam int CHAN_PITCH_W    = 16;
   localparam int OFFSET_FRAC     = 10;
   localparam int OFFSET_QW       = 17;
   localparam int CHANNEL_INDEX_W = 9;
   localparam int DETECTOR_INDEX_W = 4;
   localparam int OFFSET_W        = 16;

   localparam logic [17:0] OFFSET_BIAS     = 18'd512;
   localparam logic [17:0] POS_SAT_LIMIT   = 18'd33279;
   localparam logic [17:0] NEG_SAT_LIMIT   = 18'd32256;
   localparam logic [15:0] OFFSET_MAX      = 16'h7fff;
   localparam logic [15:0] OFFSET_MIN      = 16'h8000;

endpackage
`default_nettype wire

/* hdl/fptc_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module fptc_div_cell #(
   parameter int RW = 27,
   parameter int DW = 24,
   parameter int K  = 0,
   parameter int QW = 5,
   parameter int SW = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fptc_pkg::ctrl_type  ctrl_in,
   input  wire logic [RW-1:0]       rem_in,
   input  wire logic [QW-1:0]       quo_in,
   input  wire logic [SW-1:0]       side_in,
   input  wire logic [DW-1:0]       divisor,
   output fptc_pkg::ctrl_type       ctrl_out,
   output logic      [RW-1:0]       rem_out,
   output logic      [QW-1:0]       quo_out,
   output logic      [SW-1:0]       side_out
);

   localparam int CW = RW + DW + K + 1;

   logic [CW-1:0] rem_x;
   logic [CW-1:0] shifted;
   logic          fits;
   fptc_pkg::ctrl_type ctrl_ff;
   logic [RW-1:0] rem_ff, rem_in_v;
   logic [QW-1:0] quo_ff, quo_in_v;
   logic [SW-1:0] side_ff;

   assign rem_x    = CW'(rem_in);
   assign shifted  = CW'(divisor) << K;
   assign fits     = !ctrl_in.neg && (rem_x >= shifted);
   assign rem_in_v = fits ? rem_in - RW'(shifted) : rem_in;
   assign quo_in_v = fits ? (quo_in | (QW'(1) << K)) : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in_v;
      quo_ff  <= quo_in_v;
      side_ff <= side_in;
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign side_out = side_ff;

endmodule
`default_nettype wire

/* hdl/fptc_div_row.sv */
`timescale 1ns / 1ps
`default_nettype none
module fptc_div_row #(
   parameter int RW = 27,
   parameter int DW = 24,
   parameter int QW = 5,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fptc_pkg::ctrl_type ctrl_in,
   input  wire logic [RW-1:0] rem_in,
   input  wire logic [SW-1:0] side_in,
   input  wire logic [DW-1:0] divisor,
   output fptc_pkg::ctrl_type ctrl_out,
   output logic      [RW-1:0] rem_out,
   output logic      [QW-1:0] quo_out,
   output logic      [SW-1:0] side_out
);

   fptc_pkg::ctrl_type c [QW+1];
   logic [RW-1:0] r [QW+1];
   logic [QW-1:0] q [QW+1];
   logic [SW-1:0] s [QW+1];

   assign c[0] = ctrl_in;
   assign r[0] = rem_in;
   assign q[0] = '0;
   assign s[0] = side_in;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fptc_div_cell #(.RW(RW), .DW(DW), .K(QW - 1 - i), .QW(QW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (c[i]),
         .rem_in   (r[i]),
         .quo_in   (q[i]),
         .side_in  (s[i]),
         .divisor  (divisor),
         .ctrl_out (c[i+1]),
         .rem_out  (r[i+1]),
         .quo_out  (q[i+1]),
         .side_out (s[i+1])
      );
   end

   assign ctrl_out = c[QW];
   assign rem_out  = r[QW];
   assign quo_out  = q[QW];
   assign side_out = s[QW];

endmodule
`default_nettype wire

/* hdl/fptc_clamp.sv */
`timescale 1ns / 1ps
`default_nettype none
module fptc_clamp #(
   parameter int XW = 27,
   parameter int DW = 24,
   parameter int QW = 5,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fptc_pkg::ctrl_type ctrl_in,
   input  wire logic [QW-1:0] quo_in,
   input  wire logic [QW-2:0] last,
   input  wire logic [DW-1:0] pitch,
   input  wire logic [XW-1:0] x_in,
   input  wire logic [SW-1:0] side_in,
   output fptc_pkg::ctrl_type ctrl_out,
   output logic      [QW-2:0] quo_out,
   output logic      [XW-1:0] rem_out,
   output logic      [SW-1:0] side_out
);

   localparam int PW = DW + QW - 1;

   logic [QW-2:0] qc;
   fptc_pkg::ctrl_type ctrl1_ff, ctrl2_ff;
   logic [QW-2:0] q1_ff, q2_ff;
   logic [PW-1:0] prod_ff;
   logic [XW-1:0] x1_ff, rem_ff;
   logic [SW-1:0] s1_ff, s2_ff;

   assign qc = (quo_in > QW'(last)) ? last : quo_in[QW-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         ctrl1_ff <= ctrl_in;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      q1_ff   <= qc;
      prod_ff <= PW'(qc) * PW'(pitch);
      x1_ff   <= x_in;
      s1_ff   <= side_in;
      q2_ff   <= q1_ff;
      rem_ff  <= x1_ff - XW'(prod_ff);
      s2_ff   <= s1_ff;
   end

   assign ctrl_out = ctrl2_ff;
   assign quo_out  = q2_ff;
   assign rem_out  = rem_ff;
   assign side_out = s2_ff;

endmodule
`default_nettype wire

/* hdl/fibre_position_to_channel.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; busy is high only during reset.
// Rows of restoring-division cells form each quotient, one quotient bit per cell.
// Reset: synchronous, active high; clears the pipeline and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fibre_position_to_channel #(
   parameter int POS_WIDTH            = 26,
   parameter int MAX_DETECTORS        = 16,
   parameter int MAX_DIES             = 4,
   parameter int MAX_CHANNELS_PER_DIE = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [POS_WIDTH-1:0]          req_hit_position,
   output logic                               rsp_valid,
   output logic [3:0]                         rsp_detector_index,
   output logic [8:0]                         rsp_channel_index,
   output logic [15:0]                        rsp_offset_in_channel,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [((POS_WIDTH > 32) ? 6 : 5)-1:0] paddr,
   input  wire logic [((POS_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
   output logic      [((POS_WIDTH > 32) ? 64 : 32)-1:0] prdata,
   output logic                               pready
);

   localparam int DATA_W = (POS_WIDTH > 32) ? 64 : 32;
   localparam int AW     = (POS_WIDTH > 32) ? 6 : 5;
   localparam int ALIGN  = (POS_WIDTH > 32) ? 3 : 2;
   localparam int XW     = POS_WIDTH + 1;
   localparam int QBD    = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1;
   localparam int QBI    = (MAX_DIES > 1) ? $clog2(MAX_DIES) : 1;
   localparam int QBC    = (MAX_CHANNELS_PER_DIE > 1) ? $clog2(MAX_CHANNELS_PER_DIE) : 1;
   localparam int MW     = XW + fptc_pkg::OFFSET_FRAC + 1;
   localparam int CIW    = QBI + QBC + 11;
   localparam int DXW    = (QBD > 4) ? QBD : 4;
   localparam int LATENCY = 12 + QBD + QBI + QBC + fptc_pkg::OFFSET_QW;

   // configuration registers
   logic [POS_WIDTH-1:0] start_ff;
   logic [23:0] det_pitch_ff, die_pitch_ff;
   logic [15:0] chan_pitch_ff;
   logic [4:0]  det_count_ff;
   logic [2:0]  die_count_ff;
   logic [7:0]  chan_count_ff;
   logic        wr_en;
   fptc_pkg::reg_index_type wr_index;

   assign pready   = 1'b1;
   assign busy     = reset;
   assign wr_en    = psel && penable && pwrite && pready;
   assign wr_index = fptc_pkg::reg_index_type'(paddr[AW-1:ALIGN]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= POS_WIDTH'(fptc_pkg::START_RESET);
         det_pitch_ff  <= fptc_pkg::DETECTOR_PITCH_RESET;
         die_pitch_ff  <= fptc_pkg::DIE_PITCH_RESET;
         chan_pitch_ff <= fptc_pkg::CHANNEL_PITCH_RESET;
         det_count_ff  <= fptc_pkg::DETECTORS_RESET;
         die_count_ff  <= fptc_pkg::DIES_RESET;
         chan_count_ff <= fptc_pkg::CHANNELS_RESET;
      end else if (wr_en) begin
         unique case (wr_index)
            fptc_pkg::REG_SENSITIVE_START:   start_ff      <= pwdata[POS_WIDTH-1:0];
            fptc_pkg::REG_DETECTOR_PITCH:    det_pitch_ff  <= pwdata[23:0];
            fptc_pkg::REG_DIE_PITCH:         die_pitch_ff  <= pwdata[23:0];
            fptc_pkg::REG_CHANNEL_PITCH:     chan_pitch_ff <= pwdata[15:0];
            fptc_pkg::REG_DETECTORS_IN_MAT:  det_count_ff  <= pwdata[4:0];
            fptc_pkg::REG_DIES_PER_DETECTOR: die_count_ff  <= pwdata[2:0];
            fptc_pkg::REG_CHANNELS_PER_DIE:  chan_count_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_index)
         fptc_pkg::REG_SENSITIVE_START:   prdata = DATA_W'($signed(start_ff));
         fptc_pkg::REG_DETECTOR_PITCH:    prdata = DATA_W'(det_pitch_ff);
         fptc_pkg::REG_DIE_PITCH:         prdata = DATA_W'(die_pitch_ff);
         fptc_pkg::REG_CHANNEL_PITCH:     prdata = DATA_W'(chan_pitch_ff);
         fptc_pkg::REG_DETECTORS_IN_MAT:  prdata = DATA_W'(det_count_ff);
         fptc_pkg::REG_DIES_PER_DETECTOR: prdata = DATA_W'(die_count_ff);
         fptc_pkg::REG_CHANNELS_PER_DIE:  prdata = DATA_W'(chan_count_ff);
         default:                         prdata = '0;
      endcase
   end

   // effective pitches and last indexes
   logic [23:0] dp_eff, ip_eff;
   logic [15:0] cp_eff;
   logic [QBD-1:0] det_last;
   logic [QBI-1:0] die_last;
   logic [QBC-1:0] chan_last;
   logic [QBC:0]   chan_count_eff;

   assign dp_eff = (det_pitch_ff == '0) ? 24'd1 : det_pitch_ff;
   assign ip_eff = (die_pitch_ff == '0) ? 24'd1 : die_pitch_ff;
   assign cp_eff = (chan_pitch_ff == '0) ? 16'd1 : chan_pitch_ff;

   assign det_last  = (det_count_ff == '0) ? '0 :
                      (32'(det_count_ff) > MAX_DETECTORS) ? QBD'(MAX_DETECTORS - 1) :
                      QBD'(det_count_ff - 5'd1);
   assign die_last  = (die_count_ff == '0) ? '0 :
                      (32'(die_count_ff) > MAX_DIES) ? QBI'(MAX_DIES - 1) :
                      QBI'(die_count_ff - 3'd1);
   assign chan_last = (chan_count_ff == '0) ? '0 :
                      (32'(chan_count_ff) > MAX_CHANNELS_PER_DIE) ?
                      QBC'(MAX_CHANNELS_PER_DIE - 1) : QBC'(chan_count_ff - 8'd1);
   assign chan_count_eff = (QBC + 1)'(chan_last) + (QBC + 1)'(1);

   // subtract sensitive start
   logic [XW-1:0] x_in;
   logic [XW-1:0] x_ff;
   fptc_pkg::ctrl_type c0_ff, c0_in;

   assign x_in  = XW'($signed(req_hit_position)) - XW'($signed(start_ff));
   assign c0_in = {start && !busy, x_in[XW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
      end else begin
         c0_ff <= c0_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   // photodetector
   fptc_pkg::ctrl_type dr_ctrl, dc_ctrl;
   logic [XW-1:0]  dr_rem;
   logic [QBD:0]   dr_quo;
   logic [XW:0]    dr_side;
   logic [QBD-1:0] det;
   logic [XW-1:0]  in_det;
   logic           dc_side;

   fptc_div_row #(.RW(XW), .DW(24), .QW(QBD + 1), .SW(XW + 1)) u_det_row (
      .clock(clock), .reset(reset), .ctrl_in(c0_ff), .rem_in(x_ff),
      .side_in({c0_ff.neg, x_ff}), .divisor(dp_eff), .ctrl_out(dr_ctrl),
      .rem_out(dr_rem), .quo_out(dr_quo), .side_out(dr_side)
   );

   fptc_clamp #(.XW(XW), .DW(24), .QW(QBD + 1), .SW(1)) u_det_clamp (
      .clock(clock), .reset(reset), .ctrl_in(dr_ctrl), .quo_in(dr_quo),
      .last(det_last), .pitch(dp_eff), .x_in(dr_side[XW-1:0]), .side_in(dr_side[XW]),
      .ctrl_out(dc_ctrl), .quo_out(det), .rem_out(in_det), .side_out(dc_side)
   );

   // die
   fptc_pkg::ctrl_type ir_ctrl, ic_ctrl;
   logic [XW-1:0]      ir_rem;
   logic [QBI:0]       ir_quo;
   logic [XW+QBD:0]    ir_side;
   logic [QBI-1:0]     die;
   logic [XW-1:0]      in_die;
   logic [QBD:0]       ic_side;

   fptc_div_row #(.RW(XW), .DW(24), .QW(QBI + 1), .SW(XW + QBD + 1)) u_die_row (
      .clock(clock), .reset(reset), .ctrl_in(dc_ctrl), .rem_in(in_det),
      .side_in({dc_side, det, in_det}), .divisor(ip_eff), .ctrl_out(ir_ctrl),
      .rem_out(ir_rem), .quo_out(ir_quo), .side_out(ir_side)
   );

   fptc_clamp #(.XW(XW), .DW(24), .QW(QBI + 1), .SW(QBD + 1)) u_die_clamp (
      .clock(clock), .reset(reset), .ctrl_in(ir_ctrl), .quo_in(ir_quo),
      .last(die_last), .pitch(ip_eff), .x_in(ir_side[XW-1:0]),
      .side_in(ir_side[XW+QBD:XW]), .ctrl_out(ic_ctrl), .quo_out(die),
      .rem_out(in_die), .side_out(ic_side)
   );

   // channel
   fptc_pkg::ctrl_type cr_ctrl, cc_ctrl;
   logic [XW-1:0]          cr_rem;
   logic [QBC:0]           cr_quo;
   logic [XW+QBD+QBI:0]    cr_side;
   logic [QBC-1:0]         chan;
   logic [XW-1:0]          rem_c;
   logic [QBD+QBI:0]       cc_side;

   fptc_div_row #(.RW(XW), .DW(16), .QW(QBC + 1), .SW(XW + QBD + QBI + 1)) u_chan_row (
      .clock(clock), .reset(reset), .ctrl_in(ic_ctrl), .rem_in(in_die),
      .side_in({ic_side, die, in_die}), .divisor(cp_eff), .ctrl_out(cr_ctrl),
      .rem_out(cr_rem), .quo_out(cr_quo), .side_out(cr_side)
   );

   fptc_clamp #(.XW(XW), .DW(16), .QW(QBC + 1), .SW(QBD + QBI + 1)) u_chan_clamp (
      .clock(clock), .reset(reset), .ctrl_in(cr_ctrl), .quo_in(cr_quo),
      .last(chan_last), .pitch(cp_eff), .x_in(cr_side[XW-1:0]),
      .side_in(cr_side[XW+QBD+QBI:XW]), .ctrl_out(cc_ctrl), .quo_out(chan),
      .rem_out(rem_c), .side_out(cc_side)
   );

   // scale remainder and form channel index
   logic           p_neg;
   logic [QBD-1:0] p_det;
   logic [QBI-1:0] p_die;
   logic [XW-1:0]  mag;
   logic [CIW-1:0] ch_idx;
   fptc_pkg::ctrl_type p_ctrl_ff, p_ctrl_in;
   logic [MW-1:0]  m_ff;
   logic [8:0]     ch_idx_ff;
   logic [QBD-1:0] p_det_ff;
   logic           p_neg_ff;

   assign p_neg     = cc_side[QBD+QBI];
   assign p_det     = cc_side[QBD+QBI-1:QBI];
   assign p_die     = cc_side[QBI-1:0];
   assign mag       = p_neg ? (XW'(0) - rem_c) : rem_c;
   assign ch_idx    = CIW'(p_die) * CIW'(chan_count_eff) + CIW'(chan);
   assign p_ctrl_in = {cc_ctrl.valid, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctrl_ff <= '0;
      end else begin
         p_ctrl_ff <= p_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= MW'({mag, {fptc_pkg::OFFSET_FRAC{1'b0}}});
      ch_idx_ff <= ch_idx[8:0];
      p_det_ff  <= p_det;
      p_neg_ff  <= p_neg;
   end

   // offset within channel
   fptc_pkg::ctrl_type or_ctrl;
   logic [MW-1:0]  or_rem;
   logic [16:0]    or_quo;
   logic [QBD+9:0] or_side;

   fptc_div_row #(.RW(MW), .DW(16), .QW(fptc_pkg::OFFSET_QW), .SW(QBD + 10)) u_off_row (
      .clock(clock), .reset(reset), .ctrl_in(p_ctrl_ff), .rem_in(m_ff),
      .side_in({p_neg_ff, p_det_ff, ch_idx_ff}), .divisor(cp_eff), .ctrl_out(or_ctrl),
      .rem_out(or_rem), .quo_out(or_quo), .side_out(or_side)
   );

   logic           f_neg;
   logic [17:0]    q_pos, q_neg;
   logic [15:0]    off_in;
   logic [DXW-1:0] det_x;
   logic           valid_ff, neg_out_ff;
   logic [3:0]     det_ff;
   logic [8:0]     ch_ff;
   logic [15:0]    off_ff;

   assign f_neg = or_side[QBD+9];
   assign q_pos = 18'(or_quo);
   assign q_neg = 18'(or_quo) + 18'(or_rem != '0);
   assign det_x = DXW'(or_side[QBD+8:9]);

   always_comb begin
      if (f_neg) begin
         off_in = (q_neg > fptc_pkg::NEG_SAT_LIMIT) ? fptc_pkg::OFFSET_MIN :
                  16'(18'(0) - q_neg - fptc_pkg::OFFSET_BIAS);
      end else begin
         off_in = (q_pos > fptc_pkg::POS_SAT_LIMIT) ? fptc_pkg::OFFSET_MAX :
                  16'(q_pos - fptc_pkg::OFFSET_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= or_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      det_ff     <= det_x[3:0];
      ch_ff      <= or_side[8:0];
      off_ff     <= off_in;
      neg_out_ff <= f_neg;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_detector_index    = det_ff;
   assign rsp_channel_index     = ch_ff;
   assign rsp_offset_in_channel = off_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted transaction");

   a_before_area: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && neg_out_ff) |->
         (rsp_detector_index == 4'd0 && rsp_channel_index == 9'd0 &&
          rsp_offset_in_channel[15]))
      else $error("hit before sensitive area mapped to a channel");

endmodule
`default_nettype wire

/* dv/fibre_position_to_channel_test.sv */
`timescale 1ns / 1ps
module fibre_position_to_channel_test;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [3:0]  detector_index;
      logic [8:0]  channel_index;
      logic [15:0] offset_in_channel;
   } channel_hit_type;

   class channel_scoreboard;
      channel_hit_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function void note_hit(channel_hit_type exp_hit);
         pending.push_back(exp_hit);
      endfunction

      function void check_hit(logic [3:0] det, logic [8:0] chan, logic [15:0] off);
         channel_hit_type e;
         if (pending.size() == 0) begin
            $error("unexpected transaction det=%0d chan=%0d off=%0d", det, chan, off);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (det !== e.detector_index) begin
            $error("detector_index expected %0d actual %0d", e.detector_index, det);
            errors++;
         end
         if (chan !== e.channel_index) begin
            $error("channel_index expected %0d actual %0d", e.channel_index, chan);
            errors++;
         end
         if (off !== e.offset_in_channel) begin
            $error("offset_in_channel expected %0d actual %0d",
                   $signed(e.offset_in_channel), $signed(off));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [25:0] req_hit_position = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_detector_index;
   logic [8:0]  rsp_channel_index;
   logic [15:0] rsp_offset_in_channel;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   longint sens_start = -266404;
   longint det_pitch = 133612;
   longint die_pitch_m = 66437;
   longint chan_pitch = 1024;
   longint det_count = 4;
   longint die_count = 2;
   longint chan_count = 64;

   channel_scoreboard sb = new();
   bit idling = 1'b1;
   int quiet_cycles = 0;

   fibre_position_to_channel i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_hit_position(req_hit_position),
      .rsp_valid(rsp_valid), .rsp_detector_index(rsp_detector_index),
      .rsp_channel_index(rsp_channel_index), .rsp_offset_in_channel(rsp_offset_in_channel),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic longint eff_pitch(longint p);
      return (p == 0) ? 1 : p;
   endfunction

   function automatic longint eff_count(longint c, longint maxc);
      if (c == 0) return 1;
      if (c > maxc) return maxc;
      return c;
   endfunction

   function automatic longint clamp_quot(longint x, longint p, longint n);
      longint q;
      q = (x < 0) ? 0 : x / p;
      if (q > n - 1) q = n - 1;
      return q;
   endfunction

   function automatic channel_hit_type map_hit(logic [25:0] hit);
      channel_hit_type r;
      longint dp, ip, cp, nd, ni, nc, x, det, in_det, die, in_die, chan, num, q;
      dp = eff_pitch(det_pitch);
      ip = eff_pitch(die_pitch_m);
      cp = eff_pitch(chan_pitch);
      nd = eff_count(det_count, 16);
      ni = eff_count(die_count, 4);
      nc = eff_count(chan_count, 128);
      x = longint'($signed(hit)) - sens_start;
      det = clamp_quot(x, dp, nd);
      in_det = x - det * dp;
      die = clamp_quot(in_det, ip, ni);
      in_die = in_det - die * ip;
      chan = clamp_quot(in_die, cp, nc);
      num = (in_die - chan * cp) * 1024;
      q = num / cp;
      if (num % cp != 0 && num < 0) q -= 1;
      q -= 512;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.detector_index = det[3:0];
      r.channel_index = 9'(die * nc + chan);
      r.offset_in_channel = q[15:0];
      return r;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         fptc_pkg::REG_SENSITIVE_START:   sens_start = longint'($signed(val[25:0]));
         fptc_pkg::REG_DETECTOR_PITCH:    det_pitch = val[23:0];
         fptc_pkg::REG_DIE_PITCH:         die_pitch_m = val[23:0];
         fptc_pkg::REG_CHANNEL_PITCH:     chan_pitch = val[15:0];
         fptc_pkg::REG_DETECTORS_IN_MAT:  det_count = val[4:0];
         fptc_pkg::REG_DIES_PER_DETECTOR: die_count = val[2:0];
         fptc_pkg::REG_CHANNELS_PER_DIE:  chan_count = val[7:0];
         default: ;
      endcase
   endtask

   task automatic send_hit(logic [25:0] hit);
      int gap;
      start <= 1'b1;
      req_hit_position <= hit;
      do @(posedge clock); while (busy);
      sb.note_hit(map_hit(hit));
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic load_geometry(longint ss, longint dp, longint ip, longint cp,
                                longint nd, longint ni, longint nc);
      csr_write(fptc_pkg::REG_SENSITIVE_START, 32'(ss));
      csr_write(fptc_pkg::REG_DETECTOR_PITCH, 32'(dp));
      csr_write(fptc_pkg::REG_DIE_PITCH, 32'(ip));
      csr_write(fptc_pkg::REG_CHANNEL_PITCH, 32'(cp));
      csr_write(fptc_pkg::REG_DETECTORS_IN_MAT, 32'(nd));
      csr_write(fptc_pkg::REG_DIES_PER_DETECTOR, 32'(ni));
      csr_write(fptc_pkg::REG_CHANNELS_PER_DIE, 32'(nc));
   endtask

   task automatic random_hits(int count);
      longint span, x;
      span = eff_count(det_count, 16) * eff_pitch(det_pitch);
      if (span > (longint'(1) << 28)) span = longint'(1) << 28;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            x = longint'($urandom_range(0, 32'(span + span / 8 + 1))) - span / 16;
            send_hit(26'(sens_start + x));
         end else begin
            send_hit(26'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_hit(rsp_detector_index, rsp_channel_index, rsp_offset_in_channel);
      if (reset || (start && !busy) || rsp_valid || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      longint cp, ip, dp, nc, ni, nd;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset geometry
      send_hit(26'h2000000);
      send_hit(26'h1ffffff);
      send_hit(26'd0);
      send_hit(26'(sens_start));
      send_hit(26'(sens_start - 1));
      send_hit(26'(sens_start + 1));
      send_hit(26'(sens_start + 511));
      send_hit(26'(sens_start + 512));
      send_hit(26'(sens_start + 1023));
      send_hit(26'(sens_start + 1024));
      send_hit(26'(sens_start + 66436));
      send_hit(26'(sens_start + 66437));
      send_hit(26'(sens_start + 133611));
      send_hit(26'(sens_start + 133612));
      send_hit(26'(sens_start + 4 * 133612 - 1));
      send_hit(26'(sens_start + 4 * 133612 + 40000));
      send_hit(26'(sens_start - 40000));
      drain();

      // zero pitches and counts, unused register
      load_geometry(0, 0, 0, 0, 0, 0, 0);
      csr_write(REG_UNUSED, $urandom);
      send_hit(26'd0);
      send_hit(26'd1);
      send_hit(26'd5);
      send_hit(26'h3ffffff);
      random_hits(60);
      drain();

      // counts above maximum, tiny pitches
      load_geometry(-33554432, 1, 1, 1, 31, 7, 255);
      random_hits(60);
      drain();

      // widest pitches
      load_geometry(33554431, 16777215, 16777215, 65535, 16, 4, 128);
      send_hit(26'h1ffffff);
      send_hit(26'h2000000);
      random_hits(60);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase >= 8) idling = 1'b0;
         cp = $urandom_range(1, 3000);
         nc = $urandom_range(1, 128);
         ni = $urandom_range(1, 4);
         nd = $urandom_range(1, 16);
         ip = nc * cp + $urandom_range(0, 2 * cp);
         dp = ni * ip + $urandom_range(0, ip);
         if (ip > 16777215) ip = 16777215;
         if (dp > 16777215) dp = 16777215;
         if ($urandom_range(0, 3) == 0) begin
            nc = $urandom_range(0, 255);
            ni = $urandom_range(0, 7);
            nd = $urandom_range(0, 31);
         end
         load_geometry(longint'($signed(26'($urandom))), dp, ip, cp, nd, ni, nc);
         random_hits(100);
         drain();
      end

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
